// File: hw/rtl/tas_pkg.sv
// ----------------------------------------------------------------------------
// Texture albedo sampler package
// Shared types, register indexes, texture kinds and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tas_pkg;

  // Store geometry defaults.
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Field widths.
  localparam int COORD_W  = 17;
  localparam int COLOR_W  = 24;
  localparam int CHAN_W   = 8;
  localparam int KIND_W   = 2;
  localparam int SCALE_W  = 24;
  localparam int DIM_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_KIND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLOR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_COLOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHECKER_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd6;

  // Texture kinds.
  localparam logic [KIND_W-1:0] KIND_SOLID   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EDGES   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECKER = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BITMAP  = 2'd3;

  // Item modes.
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  // Register reset values.
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
  localparam logic [DIM_W-1:0]   DIM_RESET   = 9'd256;

  // Half of the checker fraction range.
  localparam logic [31:0] FRAC_HALF = 32'h8000_0000;

  // One in signed Q2.16.
  localparam logic signed [18:0] Q16_ONE = 19'sd65536;

  typedef struct packed {
    logic                 mode;
    logic [COORD_W-1:0]   bary_u;
    logic [COORD_W-1:0]   bary_v;
    logic [COORD_W-1:0]   tex_u;
    logic [COORD_W-1:0]   tex_v;
    logic [7:0]           texel_x;
    logic [7:0]           texel_y;
    logic [COLOR_W-1:0]   texel_rgb;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/tas_texel_ram.sv
// ----------------------------------------------------------------------------
// Texel store
// Single-port synchronous memory, one access per cycle, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tas_texel_ram #(
  parameter int DEPTH = tas_pkg::MAX_WIDTH_DEF * tas_pkg::MAX_HEIGHT_DEF,
  parameter int AW    = 16
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                addr,
  input  wire logic [tas_pkg::COLOR_W-1:0]  wdata,
  output logic      [tas_pkg::COLOR_W-1:0]  rdata
);

  logic [tas_pkg::COLOR_W-1:0] mem [DEPTH];
  logic [tas_pkg::COLOR_W-1:0] rdata_r;

  // One write or one read per cycle; read data is registered and lands in the next cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hw/rtl/texture_albedo_sampler.sv
// ----------------------------------------------------------------------------
// Texture albedo sampler
// Returns an RGB albedo per sample item in solid, edges, checker or bitmap
// mode; load items write texels into an on-chip store.
// ----------------------------------------------------------------------------
// A sample accepted into the stage-1 registers raises its result strobe from the
// stage-2 valid register; the result transfers while that strobe is high.
// Throughput: one item per cycle; the single store port serves one texel
// write or one texel read per cycle, and items reach it in order.
// Reset restores the register defaults and empties the pipeline; the texel
// store is not cleared and busy never rises. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module texture_albedo_sampler #(
  parameter int MAX_WIDTH  = tas_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tas_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input channel
  input  wire logic                           start,
  output logic                                busy,
  input  wire tas_pkg::in_item_t              in_item,
  // Result channel
  output logic                                out_valid,
  output tas_pkg::out_item_t                  out_item,
  // Configuration port
  input  wire logic                           cfg_we,
  input  wire logic [tas_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [tas_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CH    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PXW   = tas_pkg::COORD_W + CW;
  localparam int PYW   = tas_pkg::COORD_W + CH;
  localparam int PCW   = tas_pkg::COORD_W + tas_pkg::SCALE_W;

  // Configuration registers.
  logic [tas_pkg::KIND_W-1:0]  kind_r;
  logic [tas_pkg::COLOR_W-1:0] first_color_r;
  logic [tas_pkg::COLOR_W-1:0] second_color_r;
  logic [tas_pkg::COORD_W-1:0] edge_thr_r;
  logic [tas_pkg::SCALE_W-1:0] chk_scale_r;
  logic [tas_pkg::DIM_W-1:0]   img_w_r;
  logic [tas_pkg::DIM_W-1:0]   img_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r         <= tas_pkg::KIND_SOLID;
      first_color_r  <= '0;
      second_color_r <= '0;
      edge_thr_r     <= '0;
      chk_scale_r    <= tas_pkg::SCALE_RESET;
      img_w_r        <= tas_pkg::DIM_RESET;
      img_h_r        <= tas_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tas_pkg::REG_TEXTURE_KIND:   kind_r <= cfg_wdata[tas_pkg::KIND_W-1:0];
        tas_pkg::REG_FIRST_COLOR:    first_color_r <= cfg_wdata;
        tas_pkg::REG_SECOND_COLOR:   second_color_r <= cfg_wdata;
        tas_pkg::REG_EDGE_THRESHOLD: edge_thr_r <= cfg_wdata[tas_pkg::COORD_W-1:0];
        tas_pkg::REG_CHECKER_SCALE:  chk_scale_r <= cfg_wdata;
        tas_pkg::REG_IMAGE_WIDTH:    img_w_r <= cfg_wdata[tas_pkg::DIM_W-1:0];
        tas_pkg::REG_IMAGE_HEIGHT:   img_h_r <= cfg_wdata[tas_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped image size minus one, per axis.
  logic [31:0]   w_dec;
  logic [31:0]   h_dec;
  logic [CW-1:0] wm1;
  logic [CH-1:0] hm1;

  always_comb begin
    w_dec = 32'(img_w_r) - 32'd1;
    h_dec = 32'(img_h_r) - 32'd1;
    if (img_w_r == '0) begin
      wm1 = '0;
    end else if (32'(img_w_r) > 32'(MAX_WIDTH)) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = w_dec[CW-1:0];
    end
    if (img_h_r == '0) begin
      hm1 = '0;
    end else if (32'(img_h_r) > 32'(MAX_HEIGHT)) begin
      hm1 = CH'(MAX_HEIGHT - 1);
    end else begin
      hm1 = h_dec[CH-1:0];
    end
  end

  // Every cycle is open for a new item.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Stage 0: edge test and the multiplies.
  logic signed [18:0] w_third;
  logic               edge_hit;

  always_comb begin
    w_third = tas_pkg::Q16_ONE - $signed({2'b00, in_item.bary_u})
              - $signed({2'b00, in_item.bary_v});
    edge_hit = (in_item.bary_u < edge_thr_r) || (in_item.bary_v < edge_thr_r) ||
               (w_third < $signed({2'b00, edge_thr_r}));
  end

  logic                         s1_valid_r;
  logic                         s1_load_r;
  logic                         s1_edge_r;
  logic [PCW-1:0]               s1_cu_r;
  logic [PCW-1:0]               s1_cv_r;
  logic [PXW-1:0]               s1_px_r;
  logic [PYW-1:0]               s1_py_r;
  logic [7:0]                   s1_tx_r;
  logic [7:0]                   s1_ty_r;
  logic [tas_pkg::COLOR_W-1:0]  s1_rgb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_load_r <= (in_item.mode == tas_pkg::MODE_LOAD);
    s1_edge_r <= edge_hit;
    s1_cu_r   <= PCW'(in_item.tex_u) * PCW'(chk_scale_r);
    s1_cv_r   <= PCW'(in_item.tex_v) * PCW'(chk_scale_r);
    s1_px_r   <= PXW'(in_item.tex_u) * PXW'(wm1);
    s1_py_r   <= PYW'(in_item.tex_v) * PYW'(hm1);
    s1_tx_r   <= in_item.texel_x;
    s1_ty_r   <= in_item.texel_y;
    s1_rgb_r  <= in_item.texel_rgb;
  end

  // Stage 1: color choice, texel address and the store access.
  logic [PXW-17:0]              px_sh;
  logic [PYW-17:0]              py_sh;
  logic [CW-1:0]                col;
  logic [CH-1:0]                row_near;
  logic [CH-1:0]                row;
  logic                         lu;
  logic                         lv;
  logic                         load_ok;
  logic [31:0]                  ax;
  logic [31:0]                  ay;
  logic [31:0]                  addr_wide;
  logic [tas_pkg::COLOR_W-1:0]  color;
  logic                         mem_en;
  logic                         mem_we;
  logic [tas_pkg::COLOR_W-1:0]  mem_rdata;

  always_comb begin
    // Nearest texel, saturated at the last row or column, row flipped.
    px_sh = s1_px_r[PXW-1:16];
    py_sh = s1_py_r[PYW-1:16];
    col = (px_sh > (PXW-16)'(wm1)) ? wm1 : px_sh[CW-1:0];
    row_near = (py_sh > (PYW-16)'(hm1)) ? hm1 : py_sh[CH-1:0];
    row = hm1 - row_near;

    // Checker halves from the fractional part of each product.
    lu = (s1_cu_r[31:0] <= tas_pkg::FRAC_HALF);
    lv = (s1_cv_r[31:0] <= tas_pkg::FRAC_HALF);

    load_ok = (32'(s1_tx_r) < 32'(MAX_WIDTH)) && (32'(s1_ty_r) < 32'(MAX_HEIGHT));

    if (s1_load_r) begin
      ax = 32'(s1_tx_r);
      ay = 32'(s1_ty_r);
    end else begin
      ax = 32'(col);
      ay = 32'(row);
    end
    addr_wide = ay * 32'(MAX_WIDTH) + ax;

    unique case (kind_r)
      tas_pkg::KIND_SOLID:   color = first_color_r;
      tas_pkg::KIND_EDGES:   color = s1_edge_r ? first_color_r : second_color_r;
      tas_pkg::KIND_CHECKER: color = (lu == lv) ? first_color_r : second_color_r;
      tas_pkg::KIND_BITMAP:  color = first_color_r;
      default:               color = first_color_r;
    endcase

    mem_we = s1_valid_r && s1_load_r && load_ok;
    mem_en = mem_we ||
             (s1_valid_r && !s1_load_r && (kind_r == tas_pkg::KIND_BITMAP));
  end

  tas_texel_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (addr_wide[AW-1:0]),
    .wdata (s1_rgb_r),
    .rdata (mem_rdata)
  );

  // Stage 2: result strobe.
  logic                         s2_valid_r;
  logic                         s2_mem_r;
  logic [tas_pkg::COLOR_W-1:0]  s2_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r && !s1_load_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_mem_r   <= (kind_r == tas_pkg::KIND_BITMAP);
    s2_color_r <= color;
  end

  assign out_valid = s2_valid_r;
  assign out_item  = s2_mem_r ? tas_pkg::out_item_t'(mem_rdata)
                              : tas_pkg::out_item_t'(s2_color_r);

endmodule

`default_nettype wire

// File: hw/rtl/tas_checker.sv
// ----------------------------------------------------------------------------
// Texture albedo sampler checker
// Port-level assertions on the sampler, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tas_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire tas_pkg::in_item_t in_item,
  input wire logic              out_valid
);

  logic sample_xfer;
  logic load_xfer;
  assign sample_xfer = start && !busy && (in_item.mode == tas_pkg::MODE_SAMPLE);
  assign load_xfer   = start && !busy && (in_item.mode == tas_pkg::MODE_LOAD);

  // Each sample transfer, and nothing else, gives a strobe through s1_valid_r and s2_valid_r.
  a_sample_result: assert property (@(posedge clk)
    (rst_n && $past(rst_n) && $past(rst_n, 2)) |->
      (out_valid == $past(sample_xfer, 2)))
    else $error("result strobe does not match sample transfers");

  // A load transfer never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    load_xfer |=> ##1 !out_valid)
    else $error("load transfer produced a result");

  // No result in the cycle after a reset edge.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // The sampler takes an item every cycle.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

endmodule

bind texture_albedo_sampler tas_checker u_tas_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid)
);

`default_nettype wire

// File: tb/texture_albedo_sampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture albedo sampler testbench
// Drives sample and texel-load commands through all four texture kinds under
// many register settings. A scoreboard predicts every albedo from its own copy
// of the registers and the texel store, and compares the results in order.
// ----------------------------------------------------------------------------

module texture_albedo_sampler_tb;
  import tas_pkg::*;

  // Index past the last register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

  // Scoreboard: predicts the albedo of each accepted sample.
  class albedo_scoreboard;
    logic [KIND_W-1:0]  kind;
    logic [COLOR_W-1:0] color_a;
    logic [COLOR_W-1:0] color_b;
    logic [COORD_W-1:0] edge_band;
    logic [SCALE_W-1:0] checker_step;
    logic [DIM_W-1:0]   img_w;
    logic [DIM_W-1:0]   img_h;
    logic [COLOR_W-1:0] texels [STORE_DEPTH];
    bit                 texel_written [STORE_DEPTH];
    out_item_t          albedo_due [$];
    int                 errors;
    int                 reports;
    int                 samples;
    int                 loads;
    int                 results;

    function new();
      kind         = KIND_SOLID;
      color_a      = '0;
      color_b      = '0;
      edge_band    = '0;
      checker_step = SCALE_RESET;
      img_w        = DIM_RESET;
      img_h        = DIM_RESET;
    endfunction

    // Mirror a register write.
    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TEXTURE_KIND:   kind         = data[KIND_W-1:0];
        REG_FIRST_COLOR:    color_a      = data[COLOR_W-1:0];
        REG_SECOND_COLOR:   color_b      = data[COLOR_W-1:0];
        REG_EDGE_THRESHOLD: edge_band    = data[COORD_W-1:0];
        REG_CHECKER_SCALE:  checker_step = data[SCALE_W-1:0];
        REG_IMAGE_WIDTH:    img_w        = data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:   img_h        = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // A zero size acts as one, an oversize one as the store maximum.
    function int unsigned clamp_dim(input logic [DIM_W-1:0] d, input int unsigned limit);
      if (d == 0) return 1;
      if (d > limit) return limit;
      return d;
    endfunction

    // Truncating nearest texel index, saturated for coordinates above one.
    function int unsigned nearest(input logic [COORD_W-1:0] t, input int unsigned dim);
      longint unsigned p;
      p = (longint'(t) * longint'(dim - 1)) >> 16;
      if (p > dim - 1) p = dim - 1;
      return int'(p);
    endfunction

    // Store address of the texel a bitmap sample reads, with the row flipped.
    function int unsigned texel_addr(input logic [COORD_W-1:0] tu,
                                     input logic [COORD_W-1:0] tv);
      int unsigned w;
      int unsigned h;
      int unsigned col;
      int unsigned row;
      w   = clamp_dim(img_w, MAX_WIDTH_DEF);
      h   = clamp_dim(img_h, MAX_HEIGHT_DEF);
      col = nearest(tu, w);
      row = h - 1 - nearest(tv, h);
      return row * MAX_WIDTH_DEF + col;
    endfunction

    // Checker half: the fraction of the scaled coordinate, half included.
    function bit in_low_half(input logic [COORD_W-1:0] t);
      logic [63:0] prod;
      prod = 64'(t) * 64'(checker_step);
      return prod[31:0] <= FRAC_HALF;
    endfunction

    function logic [COLOR_W-1:0] albedo(input in_item_t it);
      int u;
      int v;
      int w3;
      int th;
      case (kind)
        KIND_SOLID: return color_a;
        KIND_EDGES: begin
          u  = int'(it.bary_u);
          v  = int'(it.bary_v);
          w3 = int'(Q16_ONE) - u - v;
          th = int'(edge_band);
          return (u < th || v < th || w3 < th) ? color_a : color_b;
        end
        KIND_CHECKER:
          return (in_low_half(it.tex_u) == in_low_half(it.tex_v)) ? color_a : color_b;
        default: return texels[texel_addr(it.tex_u, it.tex_v)];
      endcase
    endfunction

    // An accepted transfer: a load updates the store, a sample is predicted.
    function void note_item(input in_item_t it);
      int unsigned a;
      if (it.mode == MODE_LOAD) begin
        a = it.texel_y * MAX_WIDTH_DEF + it.texel_x;
        texels[a]        = it.texel_rgb;
        texel_written[a] = 1'b1;
        loads++;
      end else begin
        albedo_due.push_back(out_item_t'(albedo(it)));
        samples++;
      end
    endfunction

    function void report(input string msg);
      errors++;
      if (reports < 10) begin
        reports++;
        $display("%s", msg);
      end
    endfunction

    // Compare one result with the oldest prediction, channel by channel.
    function void check_result(input out_item_t got);
      out_item_t want;
      results++;
      if (albedo_due.size() == 0) begin
        report($sformatf("result %0d with none outstanding: r=%02h g=%02h b=%02h",
                         results, got.red, got.green, got.blue));
        return;
      end
      want = albedo_due.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
        report($sformatf("result %0d mismatch: expected r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h",
                         results, want.red, want.green, want.blue,
                         got.red, got.green, got.blue));
    endfunction

    function void check_drained();
      if (albedo_due.size() != 0)
        report($sformatf("%0d predicted results never arrived", albedo_due.size()));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  albedo_scoreboard sb = new();
  bit steady;
  int phases;

  texture_albedo_sampler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Results cannot be held off; check each one on its strobe.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_item);
  end

  // Mostly short gaps, a few long ones, none in steady stretches.
  function automatic int unsigned gap_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Coordinates mostly in 0..1, some at the ends, some with the top bit set.
  function automatic logic [COORD_W-1:0] pick_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return COORD_W'($urandom_range(0, 131071));
    if (r == 1) return $urandom_range(0, 1) ? COORD_W'(65536) : '0;
    return COORD_W'($urandom_range(0, 65536));
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return COLOR_W'($urandom);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return DIM_RESET;
    if (r == 2) return DIM_W'($urandom_range(257, 511));
    if (r == 3) return DIM_W'($urandom_range(1, 256));
    return DIM_W'($urandom_range(1, 12));
  endfunction

  function automatic in_item_t sample_item(input logic [COORD_W-1:0] bu,
                                           input logic [COORD_W-1:0] bv,
                                           input logic [COORD_W-1:0] tu,
                                           input logic [COORD_W-1:0] tv);
    in_item_t it;
    it.mode      = MODE_SAMPLE;
    it.bary_u    = bu;
    it.bary_v    = bv;
    it.tex_u     = tu;
    it.tex_v     = tv;
    it.texel_x   = 8'($urandom);
    it.texel_y   = 8'($urandom);
    it.texel_rgb = COLOR_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t load_item(input logic [7:0] x, input logic [7:0] y,
                                         input logic [COLOR_W-1:0] rgb);
    in_item_t it;
    it           = sample_item(pick_coord(), pick_coord(), pick_coord(), pick_coord());
    it.mode      = MODE_LOAD;
    it.texel_x   = x;
    it.texel_y   = y;
    it.texel_rgb = rgb;
    return it;
  endfunction

  // Random sample; in edges mode mostly valid weights, some near the band.
  function automatic in_item_t random_sample();
    in_item_t    it;
    int unsigned u;
    it = sample_item(pick_coord(), pick_coord(), pick_coord(), pick_coord());
    if (sb.kind == KIND_EDGES && $urandom_range(0, 9) < 7) begin
      u = $urandom_range(0, 65536);
      it.bary_u = COORD_W'(u);
      it.bary_v = COORD_W'($urandom_range(0, 65536 - u));
      if ($urandom_range(0, 2) == 0)
        it.bary_u = COORD_W'(sb.edge_band + $urandom_range(0, 2) - 1);
    end
    return it;
  endfunction

  // One command transfer: optional gap, then hold start until accepted.
  task automatic send_item(input in_item_t it);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(it);
  endtask

  // A bitmap sample of a texel never written gets a load of that texel first.
  task automatic send_sample(input in_item_t it);
    int unsigned a;
    if (sb.kind == KIND_BITMAP) begin
      a = sb.texel_addr(it.tex_u, it.tex_v);
      if (!sb.texel_written[a])
        send_item(load_item(8'(a % MAX_WIDTH_DEF), 8'(a / MAX_WIDTH_DEF), COLOR_W'($urandom)));
    end
    send_item(it);
  endtask

  // Wait for every prediction to arrive, then let any trailing load finish.
  task automatic settle();
    start <= 1'b0;
    while (sb.albedo_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write every register, plus one write to the spare index.
  task automatic program_regs(input logic [KIND_W-1:0] k, input logic [COLOR_W-1:0] ca,
                              input logic [COLOR_W-1:0] cb, input logic [COORD_W-1:0] th,
                              input logic [SCALE_W-1:0] sc, input logic [DIM_W-1:0] w,
                              input logic [DIM_W-1:0] h);
    logic [CFG_IDX_W-1:0]  idx [8];
    logic [CFG_DATA_W-1:0] val [8];
    idx = '{REG_TEXTURE_KIND, REG_FIRST_COLOR, REG_SECOND_COLOR, REG_EDGE_THRESHOLD,
            REG_CHECKER_SCALE, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_SPARE};
    val = '{CFG_DATA_W'(k), ca, cb, CFG_DATA_W'(th), sc, CFG_DATA_W'(w), CFG_DATA_W'(h),
            CFG_DATA_W'($urandom)};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    phases++;
  endtask

  // Run limit.
  initial begin
    #4_000_000;
    $display("run timed out");
    $display("texture_albedo_sampler_tb: done, errors");
    $finish;
  end

  // Stimulus.
  initial begin : stimulus
    int unsigned          random_sent;
    int unsigned          n;
    logic [COORD_W-1:0]   band;
    logic [SCALE_W-1:0]   scale;

    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    steady    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Solid: field extremes.
    program_regs(KIND_SOLID, 24'hFFFFFF, 24'h000000, '0, SCALE_RESET, DIM_RESET, DIM_RESET);
    send_sample(sample_item('0, '0, '0, '0));
    send_sample(sample_item('1, '1, '1, '1));

    // Edges: each weight under the band, the strict boundary, and overflow.
    settle();
    program_regs(KIND_EDGES, 24'h123456, 24'hABCDEF, 17'd16384, SCALE_RESET,
                 DIM_RESET, DIM_RESET);
    send_sample(sample_item(17'd0, 17'd0, pick_coord(), pick_coord()));
    send_sample(sample_item(17'd32768, 17'd32768, pick_coord(), pick_coord()));
    send_sample(sample_item(17'd21845, 17'd21845, pick_coord(), pick_coord()));
    send_sample(sample_item(17'd16384, 17'd16384, pick_coord(), pick_coord()));
    send_sample(sample_item(17'd16383, 17'd30000, pick_coord(), pick_coord()));
    send_sample(sample_item('1, '1, pick_coord(), pick_coord()));

    // Edges with a zero band: only a negative third weight is inside.
    settle();
    program_regs(KIND_EDGES, 24'h000000, 24'hFFFFFF, '0, SCALE_RESET, DIM_RESET, DIM_RESET);
    send_sample(sample_item(17'd65536, 17'd65536, pick_coord(), pick_coord()));
    send_sample(sample_item(17'd0, 17'd0, pick_coord(), pick_coord()));

    // Edges with the widest band.
    settle();
    program_regs(KIND_EDGES, 24'h00FF00, 24'hFF00FF, 17'd65536, SCALE_RESET,
                 DIM_RESET, DIM_RESET);
    send_sample(sample_item(17'd65536, 17'd0, pick_coord(), pick_coord()));

    // Checker at unit scale: exact half is the low half.
    settle();
    program_regs(KIND_CHECKER, 24'hFF0000, 24'h00FF00, '0, SCALE_RESET, DIM_RESET, DIM_RESET);
    send_sample(sample_item(pick_coord(), pick_coord(), 17'd0, 17'd0));
    send_sample(sample_item(pick_coord(), pick_coord(), 17'd32768, 17'd32769));
    send_sample(sample_item(pick_coord(), pick_coord(), 17'd65536, 17'd65536));
    send_sample(sample_item(pick_coord(), pick_coord(), 17'd32769, '1));

    // Checker with a zero scale, then the largest scale.
    settle();
    program_regs(KIND_CHECKER, 24'h0000FF, 24'hFFFF00, '0, '0, DIM_RESET, DIM_RESET);
    send_sample(sample_item(pick_coord(), pick_coord(), 17'd12345, 17'd50000));
    settle();
    program_regs(KIND_CHECKER, 24'h0000FF, 24'hFFFF00, '0, '1, DIM_RESET, DIM_RESET);
    send_sample(sample_item(pick_coord(), pick_coord(), 17'd1, 17'd65535));

    // Bitmap: zero size acts as one texel; oversize clamps to the store.
    settle();
    program_regs(KIND_BITMAP, pick_color(), pick_color(), '0, SCALE_RESET, '0, '0);
    send_sample(sample_item(pick_coord(), pick_coord(), '1, '1));
    settle();
    program_regs(KIND_BITMAP, pick_color(), pick_color(), '0, SCALE_RESET, 9'd511, 9'd300);
    send_item(load_item(8'hFF, 8'hFF, 24'hFFFFFF));
    send_sample(sample_item(pick_coord(), pick_coord(), 17'd65536, 17'd0));
    send_sample(sample_item(pick_coord(), pick_coord(), 17'd0, 17'd65536));

    // Random phases under random register settings.
    random_sent = 0;
    while (random_sent < 550) begin
      settle();
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0:       band = '0;
        1:       band = 17'd65536;
        2:       band = COORD_W'($urandom_range(0, 131071));
        default: band = COORD_W'($urandom_range(0, 40000));
      endcase
      case ($urandom_range(0, 6))
        0:       scale = '0;
        1:       scale = '1;
        2:       scale = SCALE_RESET;
        3:       scale = 24'd32768;
        4:       scale = SCALE_W'($urandom);
        default: scale = SCALE_W'($urandom_range(0, 24'h40000));
      endcase
      program_regs(KIND_W'($urandom_range(0, 3)), pick_color(), pick_color(), band, scale,
                   pick_dim(), pick_dim());
      n = $urandom_range(30, 60);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0)
          send_item(load_item(8'($urandom), 8'($urandom), COLOR_W'($urandom)));
        else
          send_sample(random_sample());
        random_sent++;
      end
    end

    // Drain and report.
    settle();
    repeat (8) @(posedge clk);
    sb.check_drained();
    $display("Covered %0d samples and %0d texel loads over %0d register settings.",
             sb.samples, sb.loads, phases);
    $display("Checked %0d results, %0d failures.", sb.results, sb.errors);
    if (sb.errors == 0) begin
      $display("texture_albedo_sampler_tb: done, clean");
    end else begin
      $display("texture_albedo_sampler_tb: done, errors");
    end
    $finish;
  end

endmodule
